[src/dqs_pkg.sv]
// Shared constants, codes and types of the double-ended queue with search.
// Used by dqs_ctrl, dqs_dp, the top level and the checker; depends on nothing.
package dqs_pkg;

  localparam int CAPACITY = 64;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STEP_W   = $clog2(CAPACITY / 2 + 1);
  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int ST_W     = 3;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 56;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_fin;
    logic srch;
    logic out_load;
  } dqs_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            srch_done;
  } dqs_stat_t;

  // Physical slot of the entry at offset off from base, modulo CAPACITY.
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

[src/dqs_dp.sv]
// Datapath: entry memory with two registered read ports, front pointer, count,
// search step counters and result/output registers. Uses dqs_pkg.
module dqs_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  dqs_pkg::dqs_cmd_t           cmd,
  output dqs_pkg::dqs_stat_t          stat,
  input  logic [dqs_pkg::OP_W-1:0]    in_op,
  input  logic [dqs_pkg::WORD_W-1:0]  in_value,
  input  logic [dqs_pkg::POS_W-1:0]   in_position,
  output logic [dqs_pkg::WORD_W-1:0]  out_data,
  output logic [dqs_pkg::STEP_W-1:0]  out_steps,
  output logic [dqs_pkg::ST_W-1:0]    out_status,
  output logic [dqs_pkg::CNT_W-1:0]   out_fill,
  output logic                        out_empty
);

  logic [dqs_pkg::OP_W-1:0]   op_r;
  logic [dqs_pkg::WORD_W-1:0] value_r;
  logic [dqs_pkg::POS_W-1:0]  pos_r;

  logic [dqs_pkg::PTR_W-1:0]  fp;
  logic [dqs_pkg::CNT_W-1:0]  cnt;
  logic [dqs_pkg::WORD_W-1:0] mem [dqs_pkg::CAPACITY];
  logic [dqs_pkg::WORD_W-1:0] rd_a;
  logic [dqs_pkg::WORD_W-1:0] rd_b;
  logic [dqs_pkg::PTR_W-1:0]  addr_a;
  logic [dqs_pkg::PTR_W-1:0]  addr_b;
  logic [dqs_pkg::PTR_W-1:0]  waddr;
  logic                       we;

  logic [dqs_pkg::CNT_W-1:0]  iss_k;
  logic [dqs_pkg::CNT_W-1:0]  cmp_k;
  logic                       cmp_v;
  logic [dqs_pkg::CNT_W:0]    cnt_inc;
  logic [dqs_pkg::CNT_W-1:0]  half;
  logic                       hit;
  logic                       full;
  logic                       empty;
  logic                       pos_bad;
  logic [dqs_pkg::PTR_W-1:0]  fp_dec;
  logic [dqs_pkg::PTR_W-1:0]  fp_inc;

  logic [dqs_pkg::WORD_W-1:0] res_data;
  logic [dqs_pkg::STEP_W-1:0] res_steps;
  logic [dqs_pkg::ST_W-1:0]   res_status;

  assign full    = (cnt == dqs_pkg::CNT_W'(dqs_pkg::CAPACITY));
  assign empty   = (cnt == '0);
  assign pos_bad = (pos_r == '0) || (dqs_pkg::CNT_W'(pos_r) > cnt);
  assign cnt_inc = {1'b0, cnt} + 1'b1;
  assign half    = cnt_inc[dqs_pkg::CNT_W:1];
  assign fp_dec  = (fp == '0) ? dqs_pkg::PTR_W'(dqs_pkg::CAPACITY - 1) : fp - 1'b1;
  assign fp_inc  = (fp == dqs_pkg::PTR_W'(dqs_pkg::CAPACITY - 1)) ? '0 : fp + 1'b1;
  assign hit     = cmp_v && ((rd_a == value_r) || (rd_b == value_r));

  assign stat.op        = op_r;
  assign stat.empty     = empty;
  assign stat.srch_done = hit || (cmp_v && (cmp_k == half));

  always_comb begin
    addr_a = fp;
    addr_b = fp;
    we     = 1'b0;
    waddr  = dqs_pkg::slot(fp, cnt);
    if (cmd.srch) begin
      addr_a = dqs_pkg::slot(fp, iss_k - 1'b1);
      addr_b = dqs_pkg::slot(fp, cnt - iss_k);
    end else begin
      case (op_r)
        dqs_pkg::OP_POP_BACK:  addr_a = dqs_pkg::slot(fp, cnt - 1'b1);
        dqs_pkg::OP_POP_FRONT: addr_a = fp;
        dqs_pkg::OP_READ:      addr_a = dqs_pkg::slot(fp, dqs_pkg::CNT_W'(pos_r) - 1'b1);
        default:               addr_a = fp;
      endcase
    end
    if (cmd.exec && !full) begin
      case (op_r)
        dqs_pkg::OP_PUSH_BACK: begin
          we    = 1'b1;
          waddr = dqs_pkg::slot(fp, cnt);
        end
        dqs_pkg::OP_PUSH_FRONT: begin
          we    = 1'b1;
          waddr = fp_dec;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= value_r;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp    <= '0;
      cnt   <= '0;
      cmp_v <= 1'b0;
    end else begin
      if (cmd.exec) begin
        cmp_v <= 1'b0;
        case (op_r)
          dqs_pkg::OP_PUSH_BACK: begin
            if (!full) cnt <= cnt + 1'b1;
          end
          dqs_pkg::OP_PUSH_FRONT: begin
            if (!full) begin
              fp  <= fp_dec;
              cnt <= cnt + 1'b1;
            end
          end
          dqs_pkg::OP_POP_BACK: begin
            if (!empty) begin
              cnt <= cnt - 1'b1;
              if (cnt == dqs_pkg::CNT_W'(1)) fp <= '0;
            end
          end
          dqs_pkg::OP_POP_FRONT: begin
            if (!empty) begin
              cnt <= cnt - 1'b1;
              fp  <= (cnt == dqs_pkg::CNT_W'(1)) ? '0 : fp_inc;
            end
          end
          default: cnt <= cnt;
        endcase
      end else if (cmd.srch) begin
        cmp_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (cmd.exec) begin
      res_data   <= '0;
      res_steps  <= '0;
      res_status <= dqs_pkg::ST_OK;
      iss_k      <= dqs_pkg::CNT_W'(1);
      case (op_r)
        dqs_pkg::OP_PUSH_BACK, dqs_pkg::OP_PUSH_FRONT: begin
          if (full) res_status <= dqs_pkg::ST_FULL;
        end
        dqs_pkg::OP_POP_BACK, dqs_pkg::OP_POP_FRONT: begin
          if (empty) res_status <= dqs_pkg::ST_EMPTY;
        end
        dqs_pkg::OP_READ: begin
          if (pos_bad) res_status <= dqs_pkg::ST_RANGE;
        end
        dqs_pkg::OP_SEARCH: res_status <= dqs_pkg::ST_NOTFOUND;
        default:            res_status <= dqs_pkg::ST_OK;
      endcase
    end
    if (cmd.srch) begin
      iss_k <= iss_k + 1'b1;
      cmp_k <= iss_k;
      if (hit) begin
        res_steps  <= cmp_k[dqs_pkg::STEP_W-1:0];
        res_status <= dqs_pkg::ST_OK;
      end
    end
    if (cmd.rd_fin && (res_status == dqs_pkg::ST_OK)) begin
      res_data <= rd_a;
    end
    if (cmd.out_load) begin
      out_data   <= res_data;
      out_steps  <= res_steps;
      out_status <= res_status;
      out_fill   <= cnt;
      out_empty  <= empty;
    end
  end

endmodule

[src/dqs_ctrl.sv]
// Controller: sequences accept, execute, memory read, search and result hand-off,
// and owns the output valid flag. Uses dqs_pkg command and status types.
module dqs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  dqs_pkg::dqs_stat_t stat,
  output dqs_pkg::dqs_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.op) inside
          dqs_pkg::OP_POP_BACK, dqs_pkg::OP_POP_FRONT, dqs_pkg::OP_READ:
            state_next = S_READ;
          dqs_pkg::OP_SEARCH:
            state_next = stat.empty ? S_DONE : S_SRCH;
          default:
            state_next = S_DONE;
        endcase
      end
      S_READ: begin
        cmd.rd_fin = 1'b1;
        state_next = S_DONE;
      end
      S_SRCH: begin
        cmd.srch = 1'b1;
        if (stat.srch_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[src/double_ended_queue_with_search.sv]
// Top level of the bounded double-ended queue with two-ended search.
// Instantiates dqs_ctrl and dqs_dp; uses dqs_pkg.
//
// Usage: one request per transfer on the s_ side (op in tuser, value and
// position in tdata), one result per request on the m_ side (data, steps,
// status, fill, empty flag).
// Requests are taken one at a time; s_tready is high only while the block is
// idle, and a held result in the output register does not stop a new request.
// Pop and read add one registered memory read before the result; a search
// adds k compare steps, where k is the match step, at most CAPACITY/2 (32),
// since two ends are compared per cycle through the memory's two read ports;
// a search of an empty queue skips the compare steps.
// The next request may be taken the cycle after the result enters the output
// register.
// Reset (rst, synchronous) empties the queue: fill 0, front slot 0, no result
// pending. Memory contents are not cleared; only written entries are read.
// When the receiver stalls, the result holds in the output register and one
// more request completes into an internal result stage before the block waits.
module double_ended_queue_with_search (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // op[2:0]
  input  logic [dqs_pkg::OP_W-1:0]   s_tuser,
  // value[31:0], position[38:32], zero pad to 40
  input  logic [dqs_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // data[31:0], steps[37:32], status[40:38], fill[47:41], empty[48], pad
  output logic [dqs_pkg::OUT_W-1:0]  m_tdata
);

  dqs_pkg::dqs_cmd_t           cmd;
  dqs_pkg::dqs_stat_t          stat;
  logic [dqs_pkg::WORD_W-1:0]  out_data;
  logic [dqs_pkg::STEP_W-1:0]  out_steps;
  logic [dqs_pkg::ST_W-1:0]    out_status;
  logic [dqs_pkg::CNT_W-1:0]   out_fill;
  logic                        out_empty;

  dqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dqs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_op        (s_tuser),
    .in_value     (s_tdata[31:0]),
    .in_position  (s_tdata[38:32]),
    .out_data     (out_data),
    .out_steps    (out_steps),
    .out_status   (out_status),
    .out_fill     (out_fill),
    .out_empty    (out_empty)
  );

  assign m_tdata = {7'b0, out_empty, out_fill, out_status, out_steps, out_data};

endmodule

[src/dqs_chk.sv]
// Port-level checker for double_ended_queue_with_search, bound to the top level.
// Uses dqs_pkg for capacity and status codes.
module dqs_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [dqs_pkg::OUT_W-1:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48] == (m_tdata[47:41] == '0)))
    else $error("empty flag disagrees with fill");

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[47:41] <= 7'(dqs_pkg::CAPACITY)))
    else $error("fill beyond capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[40:38] == dqs_pkg::ST_FULL)
      |-> (m_tdata[47:41] == 7'(dqs_pkg::CAPACITY)))
    else $error("full reported below capacity");

endmodule

bind double_ended_queue_with_search dqs_chk u_chk (.*);

[tb/double_ended_queue_with_search_test.sv]
// Self-checking testbench for double_ended_queue_with_search: drives stream requests,
// predicts every result from its own copy of the queue and checks each result transfer.
// Depends on dqs_pkg and the RTL top level only.
module double_ended_queue_with_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dqs_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [dqs_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_REPORTS = 10;
  localparam int EXP_DEPTH   = 16;

  typedef struct packed {
    logic                       empty;
    logic [dqs_pkg::CNT_W-1:0]  fill;
    logic [dqs_pkg::ST_W-1:0]   status;
    logic [dqs_pkg::STEP_W-1:0] steps;
    logic [dqs_pkg::WORD_W-1:0] data;
  } dq_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [dqs_pkg::OP_W-1:0]  s_tuser = '0;
  logic [dqs_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [dqs_pkg::OUT_W-1:0] m_tdata;

  // queue shadow
  logic [dqs_pkg::WORD_W-1:0] shadow [dqs_pkg::CAPACITY];
  logic [dqs_pkg::PTR_W-1:0]  shadow_front = '0;
  int                         shadow_fill = 0;

  // expected results, oldest at exp_rd
  dq_result_t exp_ring [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int full_hits = 0;
  int search_hits = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;
  int hold_granted = 0;
  int hold_left = 0;

  double_ended_queue_with_search DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               exp_wr - exp_rd);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [dqs_pkg::PTR_W-1:0] slot_at(input int offset);
    return dqs_pkg::PTR_W'(int'(shadow_front) + offset);
  endfunction

  function automatic dq_result_t predict_result(input logic [dqs_pkg::OP_W-1:0] op,
                                                input logic [dqs_pkg::WORD_W-1:0] val,
                                                input logic [dqs_pkg::POS_W-1:0] pos);
    dq_result_t r;
    int half;
    int i;
    bit found;
    r = '0;
    found = 1'b0;
    case (op)
      dqs_pkg::OP_PUSH_BACK, dqs_pkg::OP_PUSH_FRONT: begin
        if (shadow_fill >= dqs_pkg::CAPACITY) begin
          r.status = dqs_pkg::ST_FULL;
          full_hits++;
        end else if (op == dqs_pkg::OP_PUSH_BACK) begin
          shadow[slot_at(shadow_fill)] = val;
          shadow_fill++;
        end else begin
          shadow_front = shadow_front - 1'b1;
          shadow[shadow_front] = val;
          shadow_fill++;
        end
      end
      dqs_pkg::OP_POP_BACK, dqs_pkg::OP_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = dqs_pkg::ST_EMPTY;
        end else begin
          if (op == dqs_pkg::OP_POP_BACK) begin
            r.data = shadow[slot_at(shadow_fill - 1)];
          end else begin
            r.data = shadow[shadow_front];
            shadow_front = shadow_front + 1'b1;
          end
          shadow_fill--;
          // emptied queue restarts at slot 0
          if (shadow_fill == 0) shadow_front = '0;
        end
      end
      dqs_pkg::OP_READ: begin
        if (pos == 0 || int'(pos) > shadow_fill) begin
          r.status = dqs_pkg::ST_RANGE;
        end else begin
          r.data = shadow[slot_at(int'(pos) - 1)];
        end
      end
      dqs_pkg::OP_SEARCH: begin
        r.status = dqs_pkg::ST_NOTFOUND;
        half = (shadow_fill + 1) / 2;
        for (i = 1; i <= half && !found; i++) begin
          if (shadow[slot_at(i - 1)] == val || shadow[slot_at(shadow_fill - i)] == val) begin
            found = 1'b1;
            r.steps = dqs_pkg::STEP_W'(i);
            r.status = dqs_pkg::ST_OK;
            search_hits++;
          end
        end
      end
      default: begin
      end
    endcase
    r.fill = dqs_pkg::CNT_W'(shadow_fill);
    r.empty = (shadow_fill == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [dqs_pkg::WORD_W-1:0] want,
                                 input logic [dqs_pkg::WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: result %0d %s: expected 0x%0h, got 0x%0h", $realtime, results_checked,
               what, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    dq_result_t got;
    dq_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(dq_result_t)-1:0];
      results_checked++;
      if (exp_wr == exp_rd) begin
        report_mismatch("arrived with nothing outstanding", '0, got.data);
      end else begin
        want = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got.data !== want.data) report_mismatch("data", want.data, got.data);
        if (got.steps !== want.steps) report_mismatch("steps", want.steps, got.steps);
        if (got.status !== want.status) report_mismatch("status", want.status, got.status);
        if (got.fill !== want.fill) report_mismatch("fill", want.fill, got.fill);
        if (got.empty !== want.empty) begin
          report_mismatch("empty flag", want.empty, got.empty);
        end
      end
    end
  end

  // result receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_request != hold_granted) begin
      hold_granted <= hold_request;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic send_request(input logic [dqs_pkg::OP_W-1:0] op,
                              input logic [dqs_pkg::WORD_W-1:0] val,
                              input logic [dqs_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= dqs_pkg::IN_W'({pos, val});
    do @(posedge clk); while (!s_tready);
    exp_ring[exp_wr % EXP_DEPTH] = predict_result(op, val, pos);
    exp_wr++;
    requests_sent++;
  endtask

  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
  endtask

  function automatic logic [dqs_pkg::WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3: return dqs_pkg::WORD_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [dqs_pkg::WORD_W-1:0] pick_search_value();
    if (shadow_fill > 0 && $urandom_range(0, 9) < 7) begin
      return shadow[slot_at($urandom_range(0, shadow_fill - 1))];
    end
    return pick_value();
  endfunction

  function automatic logic [dqs_pkg::POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && shadow_fill > 0) return dqs_pkg::POS_W'($urandom_range(1, shadow_fill));
    if (r < 88) return ($urandom_range(0, 1) != 0) ? dqs_pkg::POS_W'(shadow_fill + 1) : '0;
    return dqs_pkg::POS_W'($urandom_range(0, 127));
  endfunction

  task automatic send_mixed_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) send_request(dqs_pkg::OP_PUSH_BACK, pick_value(), dqs_pkg::POS_W'($urandom));
    else if (r < 38) begin
      send_request(dqs_pkg::OP_PUSH_FRONT, pick_value(), dqs_pkg::POS_W'($urandom));
    end else if (r < 52) begin
      send_request(dqs_pkg::OP_POP_BACK, $urandom, dqs_pkg::POS_W'($urandom));
    end else if (r < 66) begin
      send_request(dqs_pkg::OP_POP_FRONT, $urandom, dqs_pkg::POS_W'($urandom));
    end else if (r < 81) begin
      send_request(dqs_pkg::OP_READ, $urandom, pick_position());
    end else if (r < 96) begin
      send_request(dqs_pkg::OP_SEARCH, pick_search_value(), dqs_pkg::POS_W'($urandom));
    end else if (r < 98) send_request(OP_UNUSED_6, $urandom, dqs_pkg::POS_W'($urandom));
    else send_request(OP_UNUSED_7, $urandom, dqs_pkg::POS_W'($urandom));
  endtask

  task automatic push_random_end(input logic [dqs_pkg::WORD_W-1:0] val);
    if ($urandom_range(0, 1) != 0) begin
      send_request(dqs_pkg::OP_PUSH_BACK, val, dqs_pkg::POS_W'($urandom));
    end else begin
      send_request(dqs_pkg::OP_PUSH_FRONT, val, dqs_pkg::POS_W'($urandom));
    end
  endtask

  task automatic pop_random_end();
    if ($urandom_range(0, 1) != 0) begin
      send_request(dqs_pkg::OP_POP_BACK, $urandom, dqs_pkg::POS_W'($urandom));
    end else begin
      send_request(dqs_pkg::OP_POP_FRONT, $urandom, dqs_pkg::POS_W'($urandom));
    end
  endtask

  task automatic test_directed_cases();
    send_request(dqs_pkg::OP_POP_BACK, 32'h0, 7'd0);
    send_request(dqs_pkg::OP_POP_FRONT, 32'hffff_ffff, 7'd127);
    send_request(dqs_pkg::OP_READ, 32'h0, 7'd1);
    send_request(dqs_pkg::OP_SEARCH, 32'h0, 7'd0);
    send_request(OP_UNUSED_6, 32'hffff_ffff, 7'd127);
    send_request(OP_UNUSED_7, 32'h0, 7'd0);
    send_request(dqs_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 7'd0);
    send_request(dqs_pkg::OP_PUSH_FRONT, 32'h8000_0000, 7'd127);
    send_request(dqs_pkg::OP_PUSH_BACK, 32'h0, 7'd0);
    send_request(dqs_pkg::OP_PUSH_FRONT, 32'hffff_ffff, 7'd0);
    send_request(dqs_pkg::OP_READ, 32'h0, 7'd0);
    send_request(dqs_pkg::OP_READ, 32'h0, 7'd1);
    send_request(dqs_pkg::OP_READ, 32'h0, 7'd4);
    send_request(dqs_pkg::OP_READ, 32'h0, 7'd5);
    send_request(dqs_pkg::OP_READ, 32'hffff_ffff, 7'd127);
    send_request(dqs_pkg::OP_SEARCH, 32'h0, 7'd0);
    send_request(dqs_pkg::OP_SEARCH, 32'h8000_0000, 7'd0);
    send_request(dqs_pkg::OP_SEARCH, 32'h1234_5678, 7'd0);
    send_request(dqs_pkg::OP_POP_FRONT, 32'h0, 7'd0);
    send_request(dqs_pkg::OP_POP_BACK, 32'h0, 7'd0);
    send_request(dqs_pkg::OP_POP_BACK, 32'h0, 7'd0);
    send_request(dqs_pkg::OP_POP_FRONT, 32'h0, 7'd0);
    // front wraps below slot 0 after the queue emptied
    send_request(dqs_pkg::OP_PUSH_FRONT, 32'h5555_5555, 7'd0);
    send_request(dqs_pkg::OP_READ, 32'h0, 7'd1);
    send_request(dqs_pkg::OP_POP_BACK, 32'h0, 7'd0);
    wait_until_drained();
  endtask

  task automatic test_fill_and_overflow();
    int k;
    while (shadow_fill < dqs_pkg::CAPACITY) push_random_end(pick_value());
    for (k = 0; k < 3; k++) push_random_end(pick_value());
    send_request(dqs_pkg::OP_READ, 32'h0, dqs_pkg::POS_W'(dqs_pkg::CAPACITY));
    send_request(dqs_pkg::OP_READ, 32'h0, dqs_pkg::POS_W'(dqs_pkg::CAPACITY + 1));
    send_request(dqs_pkg::OP_SEARCH, shadow[slot_at(dqs_pkg::CAPACITY / 2 - 1)], 7'd0);
    send_request(dqs_pkg::OP_SEARCH, shadow[slot_at(dqs_pkg::CAPACITY / 2)], 7'd0);
    send_request(dqs_pkg::OP_SEARCH, 32'hdead_beef, 7'd0);
    while (shadow_fill > 0) pop_random_end();
    pop_random_end();
    wait_until_drained();
  endtask

  task automatic test_backpressure();
    int k;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = hold_request + 1;
    for (k = 0; k < 40; k++) send_mixed_item();
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int start;
    int kind;
    int k;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    start = requests_sent;
    while (requests_sent - start < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        while (shadow_fill < dqs_pkg::CAPACITY) push_random_end(pick_value());
        push_random_end(pick_value());
      end else if (kind == 1) begin
        while (shadow_fill > 0) pop_random_end();
        pop_random_end();
      end else if (kind == 2) begin
        // sender pause until all results are back
        wait_until_drained();
      end else begin
        for (k = 0; k < 16; k++) send_mixed_item();
      end
    end
    wait_until_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_fill_and_overflow();
    test_backpressure();
    test_random_traffic(0, 0, 260);
    test_random_traffic(65, 0, 260);
    test_random_traffic(0, 65, 260);
    test_random_traffic(29, 29, 260);
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (exp_wr != exp_rd) begin
      report_mismatch("outstanding at end", '0, '0);
    end
    $display("%0d requests, %0d results checked over four idle/stall mixes and a long hold-off",
             requests_sent, results_checked);
    $display("push-when-full %0d times, searches that hit %0d, %0d field errors",
             full_hits, search_hits, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
